@@ hw/rtl/rrsa_pkg.sv @@
// Shared types and constants of the round-robin slot allocator.
package rrsa_pkg;

  // Pool size default and total widths
  localparam int SLOTS_DEFAULT = 64;
  localparam int TOTAL_W       = 22;
  localparam int COUNT_W       = 16;
  localparam int STATE_W       = 8;
  localparam int SLOT_W        = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [STATE_W-1:0] ACTIVE_BIT = 8'h01;

  // Commands
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic               load;       // place the token at the selected cell
    logic               adv;        // shift the token one cell along the ring
    logic               set;        // write set_data into the token cell
    logic               clr;        // free the token cell
    logic               find_free;  // token cell hits when free, else when occupied
    logic [STATE_W-1:0] set_data;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/rrsa_cell.sv @@
// One slot cell: state byte, token flop and hit test.
module rrsa_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rrsa_pkg::cell_ctrl_t               ctrl,
  input  logic                               load_sel,
  input  logic                               tok_in,
  output logic                               tok_out,
  output logic                               hit,
  output logic [rrsa_pkg::STATE_W-1:0]       hit_state
);
  import rrsa_pkg::*;

  logic               tok_r, tok_nxt;
  logic [STATE_W-1:0] state_r, state_nxt;

  // Move the token: load, shift from the neighbor, or hold
  always_comb begin
    if (ctrl.load) begin
      tok_nxt = load_sel;
    end else if (ctrl.adv) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  // Update the state byte only where the token sits
  always_comb begin
    state_nxt = state_r;
    if (tok_r && ctrl.set) begin
      state_nxt = ctrl.set_data | ACTIVE_BIT;
    end else if (tok_r && ctrl.clr) begin
      state_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      state_r <= '0;
    end else begin
      tok_r   <= tok_nxt;
      state_r <= state_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign hit       = tok_r && (ctrl.find_free ? (state_r == '0) : (state_r != '0));
  assign hit_state = hit ? state_r : '0;

endmodule

@@ hw/rtl/rrsa_chain.sv @@
// Ring of slot cells with hit index and state collection.
module rrsa_chain #(
  parameter int SLOTS = rrsa_pkg::SLOTS_DEFAULT,
  parameter int IW    = $clog2(SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrsa_pkg::cell_ctrl_t         ctrl,
  input  logic [IW-1:0]                load_idx,
  output logic                         hit_any,
  output logic [IW-1:0]                hit_idx,
  output logic [rrsa_pkg::STATE_W-1:0] hit_state
);
  import rrsa_pkg::*;

  logic [SLOTS-1:0] tok;
  logic [SLOTS-1:0] hit;
  logic [STATE_W-1:0] cell_state [SLOTS];

  // Build the ring; the last cell feeds the first
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rrsa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load_sel  (load_idx == IW'(i)),
      .tok_in    (tok[(i + SLOTS - 1) % SLOTS]),
      .tok_out   (tok[i]),
      .hit       (hit[i]),
      .hit_state (cell_state[i])
    );
  end

  // Encode the single hit (only one cell holds the token)
  always_comb begin
    hit_idx   = '0;
    hit_state = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_idx   = hit_idx | (hit[i] ? IW'(i) : '0);
      hit_state = hit_state | cell_state[i];
    end
  end

  assign hit_any = |hit;

endmodule

@@ hw/rtl/round_robin_slot_allocator_unit.sv @@
// Round-robin slot allocator: command sequencer, count memory and totals.
//
// A command is taken when start is high and busy is low; its one result
// appears on the out_ ports for a single cycle marked by out_valid and must be
// captured then, as the receiver cannot hold it off. Slot states live in a ring
// of cells through which a search token moves one cell per clock during a
// search. An add searches the whole ring from the rotating pointer for a free
// slot and reports full if none is found; a next searches from the start slot
// to the last slot for an occupied one; a delete tests only the given slot and
// uses the registered read of the stored counts; an invalid slot or unknown
// command is answered without a search. No reset clearing pass is needed.
module round_robin_slot_allocator_unit #(
  parameter int SLOTS = rrsa_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [rrsa_pkg::SLOT_W-1:0]  in_slot,
  input  logic                         in_from_start,
  input  logic [rrsa_pkg::COUNT_W-1:0] in_face_count,
  input  logic [rrsa_pkg::COUNT_W-1:0] in_vertex_count,
  input  logic [rrsa_pkg::STATE_W-1:0] in_flags,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [rrsa_pkg::SLOT_W-1:0]  out_found_slot,
  output logic [rrsa_pkg::STATE_W-1:0] out_found_flags,
  output logic [rrsa_pkg::TOTAL_W-1:0] out_total_faces,
  output logic [rrsa_pkg::TOTAL_W-1:0] out_total_verts
);
  import rrsa_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic {S_IDLE, S_SCAN} fsm_t;

  fsm_t               state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic               mode_r, mode_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;
  logic [TOTAL_W-1:0] face_tot_r, face_tot_nxt;
  logic [TOTAL_W-1:0] vert_tot_r, vert_tot_nxt;
  logic [COUNT_W-1:0] fc_r, vc_r;
  logic [STATE_W-1:0] flags_r;

  logic               ov_r, ov_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic [SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic [STATE_W-1:0] oflags_r, oflags_nxt;

  cell_ctrl_t         ctrl;
  logic [IW-1:0]      load_idx;
  logic               hit_any;
  logic [IW-1:0]      hit_idx;
  logic [STATE_W-1:0] hit_state;

  logic                       accept;
  logic [SLOT_W:0]            next_start;
  logic                       next_ok;
  logic                       del_ok;
  logic                       mem_wr;
  logic [2*COUNT_W-1:0]       mem [SLOTS];
  logic [2*COUNT_W-1:0]       rdata_r;
  logic [TOTAL_W:0]           face_sum, vert_sum;

  rrsa_chain #(.SLOTS(SLOTS), .IW(IW)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load_idx  (load_idx),
    .hit_any   (hit_any),
    .hit_idx   (hit_idx),
    .hit_state (hit_state)
  );

  assign accept     = start && (state_r == S_IDLE);
  assign next_start = in_from_start ? '0 : ({1'b0, in_slot} + 1'b1);
  assign next_ok    = int'(next_start) < SLOTS;
  assign del_ok     = int'(in_slot) < SLOTS;

  // Saturating add of the stored counts
  assign face_sum = {1'b0, face_tot_r} + (TOTAL_W + 1)'(fc_r);
  assign vert_sum = {1'b0, vert_tot_r} + (TOTAL_W + 1)'(vc_r);

  // Sequence one command through the ring
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    mode_nxt     = mode_r;
    remain_nxt   = remain_r;
    ptr_nxt      = ptr_r;
    face_tot_nxt = face_tot_r;
    vert_tot_nxt = vert_tot_r;
    ov_nxt       = 1'b0;
    ost_nxt      = ost_r;
    oslot_nxt    = oslot_r;
    oflags_nxt   = oflags_r;
    ctrl         = '0;
    ctrl.find_free = mode_r;
    ctrl.set_data  = flags_r;
    load_idx     = ptr_r;
    mem_wr       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_command;
          unique case (in_command)
            CMD_ADD: begin
              ctrl.load  = 1'b1;
              load_idx   = ptr_r;
              mode_nxt   = 1'b1;
              remain_nxt = CW'(SLOTS);
              state_nxt  = S_SCAN;
            end
            CMD_DEL: begin
              if (del_ok) begin
                ctrl.load  = 1'b1;
                load_idx   = IW'(in_slot);
                mode_nxt   = 1'b0;
                remain_nxt = CW'(1);
                state_nxt  = S_SCAN;
              end else begin
                ov_nxt     = 1'b1;
                ost_nxt    = ST_NONE;
                oslot_nxt  = '0;
                oflags_nxt = '0;
              end
            end
            CMD_NEXT: begin
              if (next_ok) begin
                ctrl.load  = 1'b1;
                load_idx   = IW'(next_start);
                mode_nxt   = 1'b0;
                remain_nxt = CW'(SLOTS) - CW'(next_start);
                state_nxt  = S_SCAN;
              end else begin
                ov_nxt     = 1'b1;
                ost_nxt    = ST_NONE;
                oslot_nxt  = '0;
                oflags_nxt = '0;
              end
            end
            default: begin
              ov_nxt     = 1'b1;
              ost_nxt    = ST_NONE;
              oslot_nxt  = '0;
              oflags_nxt = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          // Token cell matches: finish the command
          state_nxt  = S_IDLE;
          ov_nxt     = 1'b1;
          ost_nxt    = ST_OK;
          oslot_nxt  = '0;
          oflags_nxt = '0;
          case (cmd_r)
            CMD_ADD: begin
              ctrl.set     = 1'b1;
              mem_wr       = 1'b1;
              ptr_nxt      = (int'(hit_idx) == SLOTS - 1) ? '0 : hit_idx + 1'b1;
              face_tot_nxt = (face_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ?
                             TOTAL_MAX : face_sum[TOTAL_W-1:0];
              vert_tot_nxt = (vert_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ?
                             TOTAL_MAX : vert_sum[TOTAL_W-1:0];
              oslot_nxt    = SLOT_W'(hit_idx);
              oflags_nxt   = flags_r | ACTIVE_BIT;
            end
            CMD_DEL: begin
              ctrl.clr     = 1'b1;
              face_tot_nxt = (TOTAL_W'(rdata_r[2*COUNT_W-1:COUNT_W]) > face_tot_r) ?
                             '0 : face_tot_r - TOTAL_W'(rdata_r[2*COUNT_W-1:COUNT_W]);
              vert_tot_nxt = (TOTAL_W'(rdata_r[COUNT_W-1:0]) > vert_tot_r) ?
                             '0 : vert_tot_r - TOTAL_W'(rdata_r[COUNT_W-1:0]);
            end
            default: begin
              oslot_nxt  = SLOT_W'(hit_idx);
              oflags_nxt = hit_state;
            end
          endcase
        end else if (remain_r == CW'(1)) begin
          // Ran out of cells: report full or nothing found
          state_nxt  = S_IDLE;
          ov_nxt     = 1'b1;
          ost_nxt    = (cmd_r == CMD_ADD) ? ST_FULL : ST_NONE;
          oslot_nxt  = '0;
          oflags_nxt = '0;
        end else begin
          ctrl.adv   = 1'b1;
          remain_nxt = remain_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, totals and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ptr_r      <= '0;
      face_tot_r <= '0;
      vert_tot_r <= '0;
      ov_r       <= 1'b0;
      ost_r      <= '0;
      oslot_r    <= '0;
      oflags_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      face_tot_r <= face_tot_nxt;
      vert_tot_r <= vert_tot_nxt;
      ov_r       <= ov_nxt;
      ost_r      <= ost_nxt;
      oslot_r    <= oslot_nxt;
      oflags_r   <= oflags_nxt;
    end
  end

  // Capture the command payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    mode_r   <= mode_nxt;
    remain_r <= remain_nxt;
    if (accept) begin
      fc_r    <= in_face_count;
      vc_r    <= in_vertex_count;
      flags_r <= in_flags;
    end
  end

  // Store counts on allocation; read them back for a delete
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[hit_idx] <= {fc_r, vc_r};
    end
    if (accept) begin
      rdata_r <= mem[IW'(in_slot)];
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_found_slot  = oslot_r;
  assign out_found_flags = oflags_r;
  assign out_total_faces = face_tot_r;
  assign out_total_verts = vert_tot_r;

endmodule
